[src/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int ROW_W         = 11;
    localparam int MAX_ROWS      = 1024;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int WIN_N         = 9;
    localparam int MED_IDX       = 4;
    localparam int SORT_STAGES   = 9;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic valid;
        logic last;
    } sort_tag_t;

endpackage

[src/mf3_line_buf.sv]
// ----------------------------------------------------------------------------
// mf3_line_buf
// Two line memories (previous row, row before it), one read and one write
// per cycle, registered read with same-cycle write forwarding.
// ----------------------------------------------------------------------------
module mf3_line_buf import mf3_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_WIDTH_DEF)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pix_t          wr_mid,
    input  pix_t          wr_top,
    output pix_t          rd_mid,
    output pix_t          rd_top
);

    pix_t mid_mem [DEPTH];
    pix_t top_mem [DEPTH];

    pix_t mid_q_reg;
    pix_t top_q_reg;
    pix_t fwd_mid_reg;
    pix_t fwd_top_reg;
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mid_mem[wr_addr] <= wr_mid;
            top_mem[wr_addr] <= wr_top;
        end
        if (rd_en)
        begin
            mid_q_reg   <= mid_mem[rd_addr];
            top_q_reg   <= top_mem[rd_addr];
            fwd_mid_reg <= wr_mid;
            fwd_top_reg <= wr_top;
        end
    end

    // write landing on the address being read wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_mid = hit_reg ? fwd_mid_reg : mid_q_reg;
    assign rd_top = hit_reg ? fwd_top_reg : top_q_reg;

endmodule

[src/mf3_sort_cell.sv]
// ----------------------------------------------------------------------------
// mf3_sort_cell
// One step of an odd-even transposition sort over nine pixels, registered.
// ----------------------------------------------------------------------------
module mf3_sort_cell import mf3_pkg::*;
#(
    parameter bit ODD = 1'b0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  sort_tag_t in_tag,
    input  win_t      in_vals,
    output sort_tag_t out_tag,
    output win_t      out_vals
);

    sort_tag_t tag_reg;
    win_t      vals_reg;
    win_t      vals_next;

    always_comb
    begin
        vals_next = in_vals;
        for (int k = int'(ODD); k < WIN_N - 1; k += 2)
        begin
            if (in_vals[k] > in_vals[k+1])
            begin
                vals_next[k]   = in_vals[k+1];
                vals_next[k+1] = in_vals[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (advance)
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vals_reg <= vals_next;
        end
    end

    assign out_tag  = tag_reg;
    assign out_vals = vals_reg;

endmodule

[src/median_filter_3x3.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster stream of 8-bit grey pixels, replicated
// borders, frame size from configuration.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one word per clock while out_ready is
// high. Each accepted word passes one line-memory read stage and then a
// chain of nine sort cells, the last of which is the output register.
// A stall on the output holds the whole pipe and drops in_ready. Results
// lag the pixels by image_width + 1 words; after the last pixel of a frame,
// send image_width + 1 flush words to drain them, the last one flagged with
// last_of_frame. A flush sent mid-frame is dropped. The line memories need
// no clearing after reset, so words are taken from the first cycle. Write
// image_width and image_height only between frames.
// ----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     median_value,
    output logic                 last_of_frame
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > CFG_W) ? WW : CFG_W;

    // configuration
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W'(WIDTH_RESET);
            image_height_reg <= CFG_W'(HEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    logic [CW-1:0]    width_ext;
    logic [WW-1:0]    used_w;
    logic [ROW_W-1:0] used_h;
    logic [ROW_W-1:0] h_plus1;

    assign width_ext = CW'(image_width_reg);

    always_comb
    begin
        if (width_ext == '0)
            used_w = WW'(1);
        else if (width_ext > CW'(MAX_WIDTH))
            used_w = WW'(MAX_WIDTH);
        else
            used_w = width_ext[WW-1:0];

        if (image_height_reg == '0)
            used_h = ROW_W'(1);
        else if (image_height_reg > ROW_W'(MAX_ROWS))
            used_h = ROW_W'(MAX_ROWS);
        else
            used_h = image_height_reg;
    end

    assign h_plus1 = used_h + ROW_W'(1);

    // input position
    logic             advance;
    logic             accept;
    logic [AW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    col_next;
    logic [ROW_W-1:0] row_next;

    logic [AW-1:0]    c1, c2;
    logic [ROW_W-1:0] r1, r2;
    logic [WW-1:0]    c3;
    logic             drain, ignored, finish, emit_left, emit_norm;

    sort_tag_t sort_tag  [SORT_STAGES+1];
    win_t      sort_vals [SORT_STAGES+1];

    always_comb
    begin
        if (WW'(col_reg) >= used_w)
        begin
            c1 = '0;
            r1 = row_reg + ROW_W'(1);
        end
        else
        begin
            c1 = col_reg;
            r1 = row_reg;
        end

        if (r1 > h_plus1)
        begin
            c2 = '0;
            r2 = h_plus1;
        end
        else
        begin
            c2 = c1;
            r2 = r1;
        end

        drain     = r2 >= used_h;
        ignored   = !drain && (operation == OP_FLUSH);
        finish    = r2 >= h_plus1;
        emit_left = (c2 == '0) && (r2 >= ROW_W'(2));
        emit_norm = (c2 != '0) && (r2 >= ROW_W'(1));
        c3        = WW'(c2) + WW'(1);

        priority if (ignored)
        begin
            col_next = c2;
            row_next = r2;
        end
        else if (finish)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c3 >= used_w)
        begin
            col_next = '0;
            row_next = r2 + ROW_W'(1);
        end
        else
        begin
            col_next = c3[AW-1:0];
            row_next = r2;
        end
    end

    assign out_valid = sort_tag[SORT_STAGES].valid;
    assign advance   = !out_valid || out_ready;
    assign in_ready  = advance;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line-memory read stage
    logic          b_valid_reg;
    logic          b_active_reg;
    logic          b_emit_left_reg;
    logic          b_emit_norm_reg;
    logic          b_last_reg;
    logic          b_col0_reg;
    logic          b_drain_reg;
    logic          b_rge1_reg;
    logic          b_rge2_reg;
    pix_t          b_pix_reg;
    logic [AW-1:0] b_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= accept && !ignored;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_active_reg    <= !finish;
            b_emit_left_reg <= emit_left;
            b_emit_norm_reg <= emit_norm;
            b_last_reg      <= r2 == h_plus1;
            b_col0_reg      <= c2 == '0;
            b_drain_reg     <= drain;
            b_rge1_reg      <= r2 >= ROW_W'(1);
            b_rge2_reg      <= r2 >= ROW_W'(2);
            b_pix_reg       <= pixel;
            b_addr_reg      <= c2;
        end
    end

    pix_t rd_mid, rd_top;
    pix_t mid, top, bot;
    logic wr_en;

    assign mid   = b_rge1_reg ? rd_mid : b_pix_reg;
    assign top   = b_rge2_reg ? rd_top : mid;
    assign bot   = b_drain_reg ? mid : b_pix_reg;
    assign wr_en = advance && b_valid_reg && b_active_reg;

    mf3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (c2),
        .wr_en   (wr_en),
        .wr_addr (b_addr_reg),
        .wr_mid  (bot),
        .wr_top  (rd_mid),
        .rd_mid  (rd_mid),
        .rd_top  (rd_top)
    );

    // 3x3 window, row-major
    win_t window_reg;
    win_t window_next;

    always_comb
    begin
        window_next = window_reg;
        if (b_col0_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                window_next[c]     = top;
                window_next[3 + c] = mid;
                window_next[6 + c] = bot;
            end
        end
        else
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_next[r*3]     = window_reg[r*3 + 1];
                window_next[r*3 + 1] = window_reg[r*3 + 2];
            end
            window_next[2] = top;
            window_next[5] = mid;
            window_next[8] = bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (wr_en)
        begin
            window_reg <= window_next;
        end
    end

    // sort chain
    sort_tag_t stage0_tag;
    win_t      stage0_vals;

    always_comb
    begin
        stage0_tag.valid = b_valid_reg && (b_emit_left_reg || b_emit_norm_reg);
        stage0_tag.last  = b_emit_left_reg && b_last_reg;
        if (b_emit_left_reg)
        begin
            // right edge of the previous row, last column replicated
            for (int r = 0; r < 3; r++)
            begin
                stage0_vals[r*3]     = window_reg[r*3 + 1];
                stage0_vals[r*3 + 1] = window_reg[r*3 + 2];
                stage0_vals[r*3 + 2] = window_reg[r*3 + 2];
            end
        end
        else
        begin
            stage0_vals = window_next;
        end
    end

    assign sort_tag[0]  = stage0_tag;
    assign sort_vals[0] = stage0_vals;

    for (genvar i = 0; i < SORT_STAGES; i++)
    begin : g_cell
        mf3_sort_cell #(
            .ODD (1'(i % 2))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .in_tag   (sort_tag[i]),
            .in_vals  (sort_vals[i]),
            .out_tag  (sort_tag[i+1]),
            .out_vals (sort_vals[i+1])
        );
    end

    assign median_value  = sort_vals[SORT_STAGES][MED_IDX];
    assign last_of_frame = sort_tag[SORT_STAGES].last;

endmodule

[src/mf3_checker.sv]
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker import mf3_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] median_value,
    input logic             last_of_frame
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(median_value) && $stable(last_of_frame))
        else $error("output word changed while stalled");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output space");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output word shown during reset");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .median_value  (median_value),
    .last_of_frame (last_of_frame)
);

[tb/tb_median_filter_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3
// Self-checking testbench of the 3x3 median filter.
// ----------------------------------------------------------------------------
// A checker class keeps its own copy of the line memories, the window and the
// frame counters. It works out the expected median words from each word that
// the filter accepts, and compares each output word with the oldest one
// still pending. A short directed run covers the tiny-frame corners,
// ignored flushes and pixels sent while draining. Random frames of small
// sizes follow. Sender gaps and receiver stalls change between three phases.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3;
    import mf3_pkg::*;

    typedef enum int {FILL_UNIFORM, FILL_EXTREMES, FILL_CLUSTER} fill_t;

    class median_checker;
        typedef struct packed {
            pix_t median;
            logic last;
        } median_word_t;

        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        pix_t             line_mem [2*MAX_WIDTH_DEF];
        pix_t             win [WIN_N];
        int unsigned      col_in;
        int unsigned      row_in;
        median_word_t     pending_medians [$];
        int unsigned      mismatch_count;
        int unsigned      words_seen;

        function new();
            width_reg  = CFG_W'(WIDTH_RESET);
            height_reg = CFG_W'(HEIGHT_RESET);
            foreach (line_mem[i])
                line_mem[i] = '0;
            foreach (win[i])
                win[i] = '0;
            col_in         = 0;
            row_in         = 0;
            mismatch_count = 0;
            words_seen     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < 1)
                w = 1;
            if (w > MAX_WIDTH_DEF)
                w = MAX_WIDTH_DEF;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < 1)
                h = 1;
            if (h > MAX_ROWS)
                h = MAX_ROWS;
            return h;
        endfunction

        function pix_t middle_of_nine(pix_t v [WIN_N]);
            pix_t s [WIN_N];
            pix_t key;
            int   i;
            int   j;
            s = v;
            for (i = 1; i < WIN_N; i++)
            begin
                key = s[i];
                j   = i - 1;
                while (j >= 0 && s[j] > key)
                begin
                    s[j+1] = s[j];
                    j--;
                end
                s[j+1] = key;
            end
            return s[MED_IDX];
        endfunction

        function void note_word(logic op, pix_t px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            bit          draining;
            pix_t        top;
            pix_t        mid;
            pix_t        bot;
            pix_t        v [WIN_N];
            w = eff_width();
            h = eff_height();
            if (col_in >= w)
            begin
                col_in = 0;
                row_in++;
            end
            if (row_in > h + 1)
            begin
                row_in = h + 1;
                col_in = 0;
            end
            c        = col_in;
            r        = row_in;
            draining = (r >= h);
            if (!draining && op == OP_FLUSH)
                return;

            // column 0 closes the previous output row, right edge replicated
            if (c == 0 && r >= 2)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v[3*k]   = win[3*k+1];
                    v[3*k+1] = win[3*k+2];
                    v[3*k+2] = win[3*k+2];
                end
                pending_medians.push_back('{middle_of_nine(v), r == h + 1});
            end

            if (r >= h + 1)
            begin
                col_in = 0;
                row_in = 0;
                return;
            end

            mid = (r >= 1) ? line_mem[c] : px;
            top = (r >= 2) ? line_mem[MAX_WIDTH_DEF + c] : mid;
            bot = draining ? mid : px;
            line_mem[MAX_WIDTH_DEF + c] = line_mem[c];
            line_mem[c]                 = bot;

            if (c == 0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win[k]   = top;
                    win[3+k] = mid;
                    win[6+k] = bot;
                end
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win[3*k]   = win[3*k+1];
                    win[3*k+1] = win[3*k+2];
                end
                win[2] = top;
                win[5] = mid;
                win[8] = bot;
                if (r >= 1)
                    pending_medians.push_back('{middle_of_nine(win), 1'b0});
            end

            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            col_in = c;
            row_in = r;
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("MISMATCH @%0t word %0d: %s", $realtime, words_seen, msg);
        endtask

        task check_word(pix_t med, logic last);
            median_word_t want;
            words_seen++;
            if (pending_medians.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word median=%0d last=%0b", med, last));
                return;
            end
            want = pending_medians.pop_front();
            if (med !== want.median)
                report_mismatch($sformatf("median_value %0d, want %0d", med, want.median));
            if (last !== want.last)
                report_mismatch($sformatf("last_of_frame %0b, want %0b", last, want.last));
        endtask
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic                 operation     = OP_PIXEL;
    logic [PIX_W-1:0]     pixel         = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [PIX_W-1:0]     median_value;
    logic                 last_of_frame;

    median_checker sb;
    int unsigned   send_idle_pct = 34;
    int unsigned   stall_pct     = 53;
    int unsigned   data_words    = 0;
    bit            pause_pending = 1'b1;

    median_filter_3x3 u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .median_value  (median_value),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(median_value, last_of_frame);
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(logic op, pix_t px);
        in_valid  <= 1'b1;
        operation <= op;
        pixel     <= px;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(op, px);
    endtask

    task automatic after_word();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic feed(logic op, pix_t px);
        send_word(op, px);
        after_word();
    endtask

    // drop valid, wait for all pending words, then let the pipe run dry
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_medians.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic pix_t pick_pixel(fill_t fill, pix_t base);
        case (fill)
            FILL_UNIFORM:  return pix_t'($urandom);
            FILL_EXTREMES: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:       return base + pix_t'($urandom_range(3));
        endcase
    endfunction

    // one full frame at the current size, then the drain words
    task automatic run_frame(fill_t fill);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned k;
        pix_t        base;
        w     = sb.eff_width();
        h     = sb.eff_height();
        total = w * h;
        base  = pix_t'($urandom);
        for (k = 0; k < total; k++)
        begin
            if ($urandom_range(99) < 8)
                feed(OP_FLUSH, pix_t'($urandom));
            send_word(OP_PIXEL, pick_pixel(fill, base));
            data_words++;
            if (pause_pending && k == total / 2)
            begin
                pause_pending = 1'b0;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending_medians.size() != 0);
            end
            else
                after_word();
        end
        for (k = 0; k <= w; k++)
        begin
            if ($urandom_range(99) < 15)
                send_word(OP_PIXEL, pix_t'($urandom));
            else
                send_word(OP_FLUSH, pix_t'($urandom));
            data_words++;
            after_word();
        end
    endtask

    task automatic random_frame();
        settle();
        if ($urandom_range(1))
            write_reg(REG_IMAGE_WIDTH,
                      CFG_W'(($urandom_range(4) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8)));
        if ($urandom_range(1))
            write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 6)));
        run_frame(fill_t'($urandom_range(2)));
    endtask

    task automatic random_phase(int unsigned quota);
        int unsigned start;
        start = data_words;
        while (data_words - start < quota)
            random_frame();
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 frame: ignored flushes at start and mid-frame, pixel while draining
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        feed(OP_FLUSH, 8'h5A);
        feed(OP_PIXEL, 8'h00);
        feed(OP_PIXEL, 8'hFF);
        feed(OP_PIXEL, 8'h80);
        feed(OP_FLUSH, 8'hA5);
        feed(OP_PIXEL, 8'h01);
        feed(OP_PIXEL, 8'hFE);
        feed(OP_PIXEL, 8'h7F);
        feed(OP_FLUSH, 8'h00);
        feed(OP_PIXEL, 8'hFF);
        feed(OP_FLUSH, 8'hFF);
        feed(OP_FLUSH, 8'h00);

        // zero size registers count as a 1x1 frame
        settle();
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        feed(OP_FLUSH, 8'h0F);
        feed(OP_PIXEL, 8'hFF);
        feed(OP_PIXEL, 8'h00);
        feed(OP_FLUSH, 8'hF0);

        random_phase(120);

        send_idle_pct = 53;
        stall_pct     = 34;
        random_phase(120);

        send_idle_pct = 0;
        stall_pct     = 0;
        random_phase(120);

        settle();
        if (sb.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[files.f]
src/mf3_pkg.sv
src/mf3_line_buf.sv
src/mf3_sort_cell.sv
src/median_filter_3x3.sv
src/mf3_checker.sv
tb/tb_median_filter_3x3.sv
